### rtl/pfcpi_pkg.sv
`timescale 1ns / 1ps

package pfcpi_pkg;

  // Datapath widths: multiplier operands, product, accumulator, error, drive and amplitude factor.
  localparam int unsigned A_W   = 25;
  localparam int unsigned B_W   = 33;
  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned ACC_W = 60;
  localparam int unsigned ERR_W = 32;
  localparam int unsigned DRV_W = 17;
  localparam int unsigned AMP_W = 24;

  // Result field widths.
  localparam int unsigned DUTY_W = 16;
  localparam int unsigned IREF_W = 22;

  // Configuration port geometry.
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_IDX_W = 3;

  // Scaling and limit constants, sixteen fraction bits.
  localparam int unsigned VOLT_K         = 38758;
  localparam int unsigned CUR_K          = 3203;
  localparam int unsigned CUR_OFFSET     = 1638400;
  localparam int unsigned CUR_REF_MAX    = 2621440;
  localparam int unsigned CUR_DRIVE_MAX  = 52429;
  localparam int unsigned VOLT_DRIVE_MAX = 65536;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_VOLTAGE_TARGET = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_VOLT_GAIN_NEW  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VOLT_GAIN_OLD  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CUR_GAIN_NEW   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CUR_GAIN_OLD   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OUTER_DIVIDE   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DUTY_SPAN      = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CURRENT_SCALE  = 3'd7;

  // Register values after reset.
  localparam logic [25:0] RST_VOLTAGE_TARGET = 26'd26214400;
  localparam logic [23:0] RST_VOLT_GAIN_NEW  = 24'd53419;
  localparam logic [23:0] RST_VOLT_GAIN_OLD  = 24'd37849;
  localparam logic [23:0] RST_CUR_GAIN_NEW   = 24'd452985;
  localparam logic [23:0] RST_CUR_GAIN_OLD   = 24'd314573;
  localparam logic [7:0]  RST_OUTER_DIVIDE   = 8'd20;
  localparam logic [15:0] RST_DUTY_SPAN      = 16'd699;
  localparam logic [23:0] RST_CURRENT_SCALE  = 24'd1090519;

  typedef struct packed {
    logic [25:0] voltage_target;
    logic [23:0] volt_gain_new;
    logic [23:0] volt_gain_old;
    logic [23:0] cur_gain_new;
    logic [23:0] cur_gain_old;
    logic [7:0]  outer_divide;
    logic [15:0] duty_span;
    logic [23:0] current_scale;
  } cfg_t;

  // Microcode fields.
  typedef enum logic [2:0] {
    A_VCODE, A_ICODE, A_LCODE, A_AMP, A_GAIN_NEW, A_GAIN_OLD, A_DUTY_SPAN, A_CUR_SCALE
  } a_sel_e;

  typedef enum logic [2:0] {
    B_VOLT_K, B_CUR_K, B_T, B_E, B_ERR_PREV, B_DRIVE
  } b_sel_e;

  typedef enum logic [2:0] {
    X_ZERO, X_OFFSET, X_TARGET, X_IREF, X_DRIVE, X_ACC
  } x_sel_e;

  typedef enum logic [2:0] {
    Y_ZERO, Y_P, Y_P_SH24, Y_P_SH16, Y_ACC_SH24, Y_T, Y_ACC
  } y_sel_e;

  typedef enum logic [1:0] {
    SAT_NONE, SAT_S32, SAT_IREF, SAT_DRIVE
  } sat_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_T, DST_ACC, DST_E, DST_IREF, DST_DRIVE, DST_DUTY, DST_AMP
  } dst_e;

  typedef enum logic {
    LOOP_CUR, LOOP_VOLT
  } loop_e;

  typedef enum logic [1:0] {
    FLOW_NEXT, FLOW_BRANCH, FLOW_EMIT
  } flow_e;

  localparam int unsigned PC_W = 5;
  localparam logic [PC_W-1:0] STEP_EMIT = PC_W'(18);

  typedef struct packed {
    logic            mul_en;
    a_sel_e          a_sel;
    b_sel_e          b_sel;
    x_sel_e          x_sel;
    logic            y_neg;
    y_sel_e          y_sel;
    sat_e            sat;
    dst_e            dst;
    loop_e           loop;
    flow_e           flow;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Control word of the current step, qualified by the busy flag.
  typedef struct packed {
    logic  en;
    ctrl_t cw;
  } step_t;

  // Status returned from the datapath to the sequencer.
  typedef struct packed {
    logic outer_due;
    logic out_free;
  } stat_t;

  // Control store. Products are held in the product register, where the step after issue reads them.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    cw.mul_en = 1'b0;
    cw.a_sel  = A_LCODE;
    cw.b_sel  = B_VOLT_K;
    cw.x_sel  = X_ZERO;
    cw.y_neg  = 1'b0;
    cw.y_sel  = Y_ZERO;
    cw.sat    = SAT_NONE;
    cw.dst    = DST_NONE;
    cw.loop   = LOOP_CUR;
    cw.flow   = FLOW_NEXT;
    cw.target = '0;
    case (pc)
      // Line voltage in volts.
      5'd0: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_LCODE;
        cw.b_sel  = B_VOLT_K;
      end
      // Keep the line voltage, start the current conversion.
      5'd1: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_ICODE;
        cw.b_sel  = B_CUR_K;
        cw.y_sel  = Y_P;
        cw.dst    = DST_T;
      end
      // Reference product; actual current is the offset minus the scaled code.
      5'd2: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_AMP;
        cw.b_sel  = B_T;
        cw.x_sel  = X_OFFSET;
        cw.y_neg  = 1'b1;
        cw.y_sel  = Y_P;
        cw.dst    = DST_ACC;
      end
      // Current reference, limited; output voltage conversion issued.
      5'd3: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_VCODE;
        cw.b_sel  = B_VOLT_K;
        cw.y_sel  = Y_P_SH24;
        cw.sat    = SAT_IREF;
        cw.dst    = DST_IREF;
      end
      // Current error.
      5'd4: begin
        cw.x_sel  = X_IREF;
        cw.y_neg  = 1'b1;
        cw.y_sel  = Y_ACC;
        cw.sat    = SAT_S32;
        cw.dst    = DST_E;
      end
      // Keep the output voltage, newest error term of the current loop.
      5'd5: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_GAIN_NEW;
        cw.b_sel  = B_E;
        cw.y_sel  = Y_P;
        cw.dst    = DST_T;
      end
      5'd6: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_GAIN_OLD;
        cw.b_sel  = B_ERR_PREV;
        cw.y_sel  = Y_P;
        cw.dst    = DST_ACC;
      end
      5'd7: begin
        cw.x_sel  = X_ACC;
        cw.y_neg  = 1'b1;
        cw.y_sel  = Y_P;
        cw.dst    = DST_ACC;
      end
      // New current drive.
      5'd8: begin
        cw.x_sel  = X_DRIVE;
        cw.y_sel  = Y_ACC_SH24;
        cw.sat    = SAT_DRIVE;
        cw.dst    = DST_DRIVE;
      end
      5'd9: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_DUTY_SPAN;
        cw.b_sel  = B_DRIVE;
      end
      // Duty count; skip the voltage loop unless the divider has run out.
      5'd10: begin
        cw.y_sel  = Y_P_SH16;
        cw.dst    = DST_DUTY;
        cw.flow   = FLOW_BRANCH;
        cw.target = STEP_EMIT;
      end
      // Voltage error.
      5'd11: begin
        cw.x_sel  = X_TARGET;
        cw.y_neg  = 1'b1;
        cw.y_sel  = Y_T;
        cw.sat    = SAT_S32;
        cw.dst    = DST_E;
        cw.loop   = LOOP_VOLT;
      end
      5'd12: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_GAIN_NEW;
        cw.b_sel  = B_E;
        cw.loop   = LOOP_VOLT;
      end
      5'd13: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_GAIN_OLD;
        cw.b_sel  = B_ERR_PREV;
        cw.y_sel  = Y_P;
        cw.dst    = DST_ACC;
        cw.loop   = LOOP_VOLT;
      end
      5'd14: begin
        cw.x_sel  = X_ACC;
        cw.y_neg  = 1'b1;
        cw.y_sel  = Y_P;
        cw.dst    = DST_ACC;
        cw.loop   = LOOP_VOLT;
      end
      // New voltage drive.
      5'd15: begin
        cw.x_sel  = X_DRIVE;
        cw.y_sel  = Y_ACC_SH24;
        cw.sat    = SAT_DRIVE;
        cw.dst    = DST_DRIVE;
        cw.loop   = LOOP_VOLT;
      end
      5'd16: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_CUR_SCALE;
        cw.b_sel  = B_DRIVE;
        cw.loop   = LOOP_VOLT;
      end
      // New amplitude factor.
      5'd17: begin
        cw.y_sel  = Y_P_SH16;
        cw.dst    = DST_AMP;
        cw.loop   = LOOP_VOLT;
      end
      5'd18: begin
        cw.flow   = FLOW_EMIT;
      end
      default: begin
        cw.flow   = FLOW_EMIT;
      end
    endcase
    return cw;
  endfunction

endpackage

### rtl/pfcpi_if.sv
`timescale 1ns / 1ps

// Sample channel: one transfer per control tick.
interface pfcpi_in_if #(
  parameter int unsigned SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] out_volt_code;
  logic [SAMPLE_BITS-1:0] inductor_cur_code;
  logic [SAMPLE_BITS-1:0] line_volt_code;

  modport source (
    output valid, out_volt_code, inductor_cur_code, line_volt_code,
    input  ready
  );
  modport sink (
    input  valid, out_volt_code, inductor_cur_code, line_volt_code,
    output ready
  );
endinterface

// Result channel: one transfer per accepted tick.
interface pfcpi_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty_count;
  logic [21:0] current_ref;
  logic        outer_updated;

  modport source (
    output valid, duty_count, current_ref, outer_updated,
    input  ready
  );
  modport sink (
    input  valid, duty_count, current_ref, outer_updated,
    output ready
  );
endinterface

### rtl/pfcpi_regs.sv
`timescale 1ns / 1ps

module pfcpi_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfcpi_pkg::ADDR_W-1:0]  paddr,
  input  logic [pfcpi_pkg::DATA_W-1:0]  pwdata,
  output logic [pfcpi_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output pfcpi_pkg::cfg_t               cfg_o
);

  pfcpi_pkg::cfg_t                  cfg_q;
  logic [pfcpi_pkg::REG_IDX_W-1:0]  idx;
  logic                             wr_en;

  assign idx    = paddr[pfcpi_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.voltage_target <= pfcpi_pkg::RST_VOLTAGE_TARGET;
      cfg_q.volt_gain_new  <= pfcpi_pkg::RST_VOLT_GAIN_NEW;
      cfg_q.volt_gain_old  <= pfcpi_pkg::RST_VOLT_GAIN_OLD;
      cfg_q.cur_gain_new   <= pfcpi_pkg::RST_CUR_GAIN_NEW;
      cfg_q.cur_gain_old   <= pfcpi_pkg::RST_CUR_GAIN_OLD;
      cfg_q.outer_divide   <= pfcpi_pkg::RST_OUTER_DIVIDE;
      cfg_q.duty_span      <= pfcpi_pkg::RST_DUTY_SPAN;
      cfg_q.current_scale  <= pfcpi_pkg::RST_CURRENT_SCALE;
    end else if (wr_en) begin
      case (idx)
        pfcpi_pkg::REG_VOLTAGE_TARGET: cfg_q.voltage_target <= pwdata[25:0];
        pfcpi_pkg::REG_VOLT_GAIN_NEW:  cfg_q.volt_gain_new  <= pwdata[23:0];
        pfcpi_pkg::REG_VOLT_GAIN_OLD:  cfg_q.volt_gain_old  <= pwdata[23:0];
        pfcpi_pkg::REG_CUR_GAIN_NEW:   cfg_q.cur_gain_new   <= pwdata[23:0];
        pfcpi_pkg::REG_CUR_GAIN_OLD:   cfg_q.cur_gain_old   <= pwdata[23:0];
        pfcpi_pkg::REG_OUTER_DIVIDE:   cfg_q.outer_divide   <= pwdata[7:0];
        pfcpi_pkg::REG_DUTY_SPAN:      cfg_q.duty_span      <= pwdata[15:0];
        pfcpi_pkg::REG_CURRENT_SCALE:  cfg_q.current_scale  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (idx)
      pfcpi_pkg::REG_VOLTAGE_TARGET: prdata = 32'(cfg_q.voltage_target);
      pfcpi_pkg::REG_VOLT_GAIN_NEW:  prdata = 32'(cfg_q.volt_gain_new);
      pfcpi_pkg::REG_VOLT_GAIN_OLD:  prdata = 32'(cfg_q.volt_gain_old);
      pfcpi_pkg::REG_CUR_GAIN_NEW:   prdata = 32'(cfg_q.cur_gain_new);
      pfcpi_pkg::REG_CUR_GAIN_OLD:   prdata = 32'(cfg_q.cur_gain_old);
      pfcpi_pkg::REG_OUTER_DIVIDE:   prdata = 32'(cfg_q.outer_divide);
      pfcpi_pkg::REG_DUTY_SPAN:      prdata = 32'(cfg_q.duty_span);
      pfcpi_pkg::REG_CURRENT_SCALE:  prdata = 32'(cfg_q.current_scale);
      default:                       prdata = '0;
    endcase
  end

endmodule

### rtl/pfcpi_sequencer.sv
`timescale 1ns / 1ps

module pfcpi_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_accept_i,
  input  pfcpi_pkg::stat_t stat_i,
  output logic             busy_o,
  output pfcpi_pkg::step_t step_o
);

  logic [pfcpi_pkg::PC_W-1:0] pc_q;
  logic                       busy_q;
  pfcpi_pkg::ctrl_t           cw;

  // Control store lookup for the current step.
  assign cw          = pfcpi_pkg::ucode(pc_q);
  assign step_o.en   = busy_q;
  assign step_o.cw   = cw;
  assign busy_o      = busy_q;

  // Step counter with the divider branch and the final hand-over step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
    end else if (busy_q) begin
      case (cw.flow)
        pfcpi_pkg::FLOW_NEXT: begin
          pc_q <= pc_q + pfcpi_pkg::PC_W'(1);
        end
        pfcpi_pkg::FLOW_BRANCH: begin
          if (stat_i.outer_due) begin
            pc_q <= pc_q + pfcpi_pkg::PC_W'(1);
          end else begin
            pc_q <= cw.target;
          end
        end
        pfcpi_pkg::FLOW_EMIT: begin
          if (stat_i.out_free) begin
            busy_q <= 1'b0;
            pc_q   <= '0;
          end
        end
        default: begin
          busy_q <= 1'b0;
          pc_q   <= '0;
        end
      endcase
    end else if (in_accept_i) begin
      busy_q <= 1'b1;
      pc_q   <= '0;
    end
  end

endmodule

### rtl/pfcpi_datapath.sv
`timescale 1ns / 1ps

module pfcpi_datapath #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_accept_i,
  input  logic [SAMPLE_BITS-1:0] out_volt_code_i,
  input  logic [SAMPLE_BITS-1:0] inductor_cur_code_i,
  input  logic [SAMPLE_BITS-1:0] line_volt_code_i,
  input  pfcpi_pkg::step_t       step_i,
  input  pfcpi_pkg::cfg_t        cfg_i,
  input  logic                   out_ready_i,
  output pfcpi_pkg::stat_t       stat_o,
  output logic                   out_valid_o,
  output logic [15:0]            duty_count_o,
  output logic [21:0]            current_ref_o,
  output logic                   outer_updated_o
);

  localparam int unsigned A_W   = pfcpi_pkg::A_W;
  localparam int unsigned B_W   = pfcpi_pkg::B_W;
  localparam int unsigned P_W   = pfcpi_pkg::P_W;
  localparam int unsigned ACC_W = pfcpi_pkg::ACC_W;
  localparam int unsigned ERR_W = pfcpi_pkg::ERR_W;
  localparam int unsigned DRV_W = pfcpi_pkg::DRV_W;
  localparam int unsigned AMP_W = pfcpi_pkg::AMP_W;

  localparam logic signed [ACC_W-1:0] S32_MAX  = ACC_W'(2147483647);
  localparam logic signed [ACC_W-1:0] S32_MIN  = -S32_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] IREF_MAX = ACC_W'(pfcpi_pkg::CUR_REF_MAX);
  localparam logic signed [ACC_W-1:0] CDRV_MAX = ACC_W'(pfcpi_pkg::CUR_DRIVE_MAX);
  localparam logic signed [ACC_W-1:0] VDRV_MAX = ACC_W'(pfcpi_pkg::VOLT_DRIVE_MAX);
  localparam logic signed [ACC_W-1:0] ZERO_VAL = ACC_W'(0);

  pfcpi_pkg::ctrl_t cw;

  // Captured samples.
  logic [SAMPLE_BITS-1:0] vcode_q;
  logic [SAMPLE_BITS-1:0] icode_q;
  logic [SAMPLE_BITS-1:0] lcode_q;

  // Working registers.
  logic signed [P_W-1:0]   p_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [B_W-1:0]   t_q;
  logic signed [ERR_W-1:0] e_q;
  logic [21:0]             iref_q;
  logic [15:0]             duty_q;
  logic                    upd_q;

  // Loop state.
  logic signed [ERR_W-1:0] cerr_q;
  logic signed [ERR_W-1:0] verr_q;
  logic [DRV_W-1:0]        cdrv_q;
  logic [DRV_W-1:0]        vdrv_q;
  logic [AMP_W-1:0]        amp_q;
  logic [7:0]              tick_q;
  logic [8:0]              tick_next;

  // Result register.
  logic        out_valid_q;
  logic [15:0] out_duty_q;
  logic [21:0] out_iref_q;
  logic        out_upd_q;

  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [ACC_W-1:0] x_val;
  logic signed [ACC_W-1:0] y_val;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] res;
  logic signed [ACC_W-1:0] drv_top;
  logic [DRV_W-1:0]        drv_sel;
  logic signed [ERR_W-1:0] err_sel;
  logic [23:0]             gain_new;
  logic [23:0]             gain_old;
  logic                    emit;
  logic                    is_volt;

  assign cw       = step_i.cw;
  assign is_volt  = (cw.loop == pfcpi_pkg::LOOP_VOLT);
  assign drv_sel  = is_volt ? vdrv_q : cdrv_q;
  assign err_sel  = is_volt ? verr_q : cerr_q;
  assign gain_new = is_volt ? cfg_i.volt_gain_new : cfg_i.cur_gain_new;
  assign gain_old = is_volt ? cfg_i.volt_gain_old : cfg_i.cur_gain_old;
  assign drv_top  = is_volt ? VDRV_MAX : CDRV_MAX;

  // Divider status and result slot status.
  assign tick_next        = {1'b0, tick_q} + 9'd1;
  assign stat_o.outer_due = (tick_next >= {1'b0, cfg_i.outer_divide});
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign emit = step_i.en && (cw.flow == pfcpi_pkg::FLOW_EMIT) && stat_o.out_free;

  // Multiplier operand selection.
  always_comb begin
    case (cw.a_sel)
      pfcpi_pkg::A_VCODE:     mul_a = A_W'(vcode_q);
      pfcpi_pkg::A_ICODE:     mul_a = A_W'(icode_q);
      pfcpi_pkg::A_LCODE:     mul_a = A_W'(lcode_q);
      pfcpi_pkg::A_AMP:       mul_a = A_W'(amp_q);
      pfcpi_pkg::A_GAIN_NEW:  mul_a = A_W'(gain_new);
      pfcpi_pkg::A_GAIN_OLD:  mul_a = A_W'(gain_old);
      pfcpi_pkg::A_DUTY_SPAN: mul_a = A_W'(cfg_i.duty_span);
      pfcpi_pkg::A_CUR_SCALE: mul_a = A_W'(cfg_i.current_scale);
      default:                mul_a = '0;
    endcase
    case (cw.b_sel)
      pfcpi_pkg::B_VOLT_K:   mul_b = B_W'(pfcpi_pkg::VOLT_K);
      pfcpi_pkg::B_CUR_K:    mul_b = B_W'(pfcpi_pkg::CUR_K);
      pfcpi_pkg::B_T:        mul_b = t_q;
      pfcpi_pkg::B_E:        mul_b = B_W'(e_q);
      pfcpi_pkg::B_ERR_PREV: mul_b = B_W'(err_sel);
      pfcpi_pkg::B_DRIVE:    mul_b = B_W'(drv_sel);
      default:               mul_b = '0;
    endcase
  end

  // Adder operands, add or subtract, then the selected limit.
  always_comb begin
    case (cw.x_sel)
      pfcpi_pkg::X_ZERO:   x_val = '0;
      pfcpi_pkg::X_OFFSET: x_val = ACC_W'(pfcpi_pkg::CUR_OFFSET);
      pfcpi_pkg::X_TARGET: x_val = ACC_W'(cfg_i.voltage_target);
      pfcpi_pkg::X_IREF:   x_val = ACC_W'(iref_q);
      pfcpi_pkg::X_DRIVE:  x_val = ACC_W'(drv_sel);
      pfcpi_pkg::X_ACC:    x_val = acc_q;
      default:             x_val = '0;
    endcase
    case (cw.y_sel)
      pfcpi_pkg::Y_ZERO:     y_val = '0;
      pfcpi_pkg::Y_P:        y_val = ACC_W'(p_q);
      pfcpi_pkg::Y_P_SH24:   y_val = ACC_W'(p_q >>> 24);
      pfcpi_pkg::Y_P_SH16:   y_val = ACC_W'(p_q >>> 16);
      pfcpi_pkg::Y_ACC_SH24: y_val = acc_q >>> 24;
      pfcpi_pkg::Y_T:        y_val = ACC_W'(t_q);
      pfcpi_pkg::Y_ACC:      y_val = acc_q;
      default:               y_val = '0;
    endcase
    sum = cw.y_neg ? (x_val - y_val) : (x_val + y_val);
    case (cw.sat)
      pfcpi_pkg::SAT_S32: begin
        if (sum > S32_MAX) begin
          res = S32_MAX;
        end else if (sum < S32_MIN) begin
          res = S32_MIN;
        end else begin
          res = sum;
        end
      end
      pfcpi_pkg::SAT_IREF: begin
        res = (sum > IREF_MAX) ? IREF_MAX : sum;
      end
      pfcpi_pkg::SAT_DRIVE: begin
        if (sum >= drv_top) begin
          res = drv_top;
        end else if (sum <= ZERO_VAL) begin
          res = '0;
        end else begin
          res = sum;
        end
      end
      default: res = sum;
    endcase
  end

  // Samples, product, working registers and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      vcode_q <= out_volt_code_i;
      icode_q <= inductor_cur_code_i;
      lcode_q <= line_volt_code_i;
    end
    if (step_i.en && cw.mul_en) begin
      p_q <= mul_a * mul_b;
    end
    if (step_i.en) begin
      case (cw.dst)
        pfcpi_pkg::DST_T:    t_q    <= res[B_W-1:0];
        pfcpi_pkg::DST_ACC:  acc_q  <= res;
        pfcpi_pkg::DST_E:    e_q    <= res[ERR_W-1:0];
        pfcpi_pkg::DST_IREF: iref_q <= res[21:0];
        pfcpi_pkg::DST_DUTY: duty_q <= res[15:0];
        default: ;
      endcase
    end
    if (emit) begin
      out_duty_q <= duty_q;
      out_iref_q <= iref_q;
      out_upd_q  <= upd_q;
    end
  end

  // Loop state, divider and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cerr_q      <= '0;
      verr_q      <= '0;
      cdrv_q      <= '0;
      vdrv_q      <= '0;
      amp_q       <= '0;
      tick_q      <= '0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step_i.en) begin
        case (cw.dst)
          pfcpi_pkg::DST_DRIVE: begin
            if (is_volt) begin
              vdrv_q <= res[DRV_W-1:0];
              verr_q <= e_q;
            end else begin
              cdrv_q <= res[DRV_W-1:0];
              cerr_q <= e_q;
            end
          end
          pfcpi_pkg::DST_AMP: amp_q <= res[AMP_W-1:0];
          default: ;
        endcase
        if (cw.flow == pfcpi_pkg::FLOW_BRANCH) begin
          if (stat_o.outer_due) begin
            tick_q <= '0;
            upd_q  <= 1'b1;
          end else begin
            tick_q <= tick_next[7:0];
            upd_q  <= 1'b0;
          end
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign duty_count_o    = out_duty_q;
  assign current_ref_o   = out_iref_q;
  assign outer_updated_o = out_upd_q;

endmodule

### rtl/pfc_cascaded_pi_controller_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Transfer when         Payload
// in_i      sink       valid && ready        out_volt_code, inductor_cur_code, line_volt_code
// out_o     source     valid && ready        duty_count, current_ref, outer_updated
// APB       slave      psel, penable, pwrite  paddr selects one of eight registers
//
// A tick occupies the sequencer from its input transfer through the current loop steps,
// and the voltage loop steps when the divider has run out; no new sample is taken until
// the sequencer is free. The tick rate is set by the single shared 25 x 33 multiplier
// stepped by the control store. Reset clears loop state, divider and amplitude factor.
// A result still waiting on the output holds the sequencer at its last step.

module pfc_cascaded_pi_controller_top #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pfcpi_in_if.sink                      in_i,
  pfcpi_out_if.source                   out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfcpi_pkg::ADDR_W-1:0]  paddr,
  input  logic [pfcpi_pkg::DATA_W-1:0]  pwdata,
  output logic [pfcpi_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  pfcpi_pkg::cfg_t  cfg;
  pfcpi_pkg::step_t step;
  pfcpi_pkg::stat_t stat;
  logic             busy;
  logic             in_accept;

  // A new tick is taken whenever the sequencer is free.
  assign in_i.ready = !busy;
  assign in_accept  = in_i.valid && !busy;

  pfcpi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pfcpi_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .stat_i      (stat),
    .busy_o      (busy),
    .step_o      (step)
  );

  pfcpi_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_accept_i         (in_accept),
    .out_volt_code_i     (in_i.out_volt_code),
    .inductor_cur_code_i (in_i.inductor_cur_code),
    .line_volt_code_i    (in_i.line_volt_code),
    .step_i              (step),
    .cfg_i               (cfg),
    .out_ready_i         (out_o.ready),
    .stat_o              (stat),
    .out_valid_o         (out_o.valid),
    .duty_count_o        (out_o.duty_count),
    .current_ref_o       (out_o.current_ref),
    .outer_updated_o     (out_o.outer_updated)
  );

  // A tick that finishes always leaves a result waiting on the output.
  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> out_o.valid)
    else $error("tick finished without presenting a result");

  // The current drive never exceeds 0.8, so the duty count cannot pass the full-drive count.
  a_duty_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.duty_count <= cfg.duty_span))
    else $error("duty count above the full-drive count");

  // The current reference is limited to forty amperes.
  a_iref_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.current_ref <= 22'(pfcpi_pkg::CUR_REF_MAX)))
    else $error("current reference above its limit");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

// Converter sample scaling and loop limits, sixteen fraction bits.
localparam longint VOLT_SCALE     = 38758;
localparam longint CUR_SCALE      = 3203;
localparam longint CUR_ZERO       = 1638400;
localparam longint CUR_REF_LIMIT  = 2621440;
localparam longint CUR_DRIVE_TOP  = 52429;
localparam longint VOLT_DRIVE_TOP = 65536;
localparam longint S32_MAX        = 2147483647;
localparam longint S32_MIN        = -S32_MAX - 1;

// Register programme of a phase: everything at its top, everything cleared, or a mix.
typedef enum {SET_TOP, SET_FLOOR, SET_MIXED} reg_set_e;

// Outcome of one control tick.
typedef struct packed {
  logic [15:0] duty_count;
  logic [21:0] current_ref;
  logic        outer_updated;
} tick_result_t;

// Bits that each register keeps on a write.
function automatic logic [31:0] reg_mask(input logic [2:0] idx);
  case (idx)
    pfcpi_pkg::REG_VOLTAGE_TARGET: return 32'h03FF_FFFF;
    pfcpi_pkg::REG_OUTER_DIVIDE:   return 32'h0000_00FF;
    pfcpi_pkg::REG_DUTY_SPAN:      return 32'h0000_FFFF;
    default:                       return 32'h00FF_FFFF;
  endcase
endfunction

// Cascaded loop predictor and the queue of tick results still to arrive.
class pfc_tick_board;
  longint voltage_target, volt_gain_new, volt_gain_old, cur_gain_new, cur_gain_old;
  longint outer_divide, duty_span, current_scale;
  longint volt_err_prev, cur_err_prev, volt_drive, cur_drive, amp_factor, tick_count;
  tick_result_t expected_ticks[$];
  int unsigned failures;

  function new();
    voltage_target = pfcpi_pkg::RST_VOLTAGE_TARGET;
    volt_gain_new  = pfcpi_pkg::RST_VOLT_GAIN_NEW;
    volt_gain_old  = pfcpi_pkg::RST_VOLT_GAIN_OLD;
    cur_gain_new   = pfcpi_pkg::RST_CUR_GAIN_NEW;
    cur_gain_old   = pfcpi_pkg::RST_CUR_GAIN_OLD;
    outer_divide   = pfcpi_pkg::RST_OUTER_DIVIDE;
    duty_span      = pfcpi_pkg::RST_DUTY_SPAN;
    current_scale  = pfcpi_pkg::RST_CURRENT_SCALE;
    volt_err_prev  = 0;
    cur_err_prev   = 0;
    volt_drive     = 0;
    cur_drive      = 0;
    amp_factor     = 0;
    tick_count     = 0;
    failures       = 0;
  endfunction

  function void load_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      pfcpi_pkg::REG_VOLTAGE_TARGET: voltage_target = value;
      pfcpi_pkg::REG_VOLT_GAIN_NEW:  volt_gain_new  = value;
      pfcpi_pkg::REG_VOLT_GAIN_OLD:  volt_gain_old  = value;
      pfcpi_pkg::REG_CUR_GAIN_NEW:   cur_gain_new   = value;
      pfcpi_pkg::REG_CUR_GAIN_OLD:   cur_gain_old   = value;
      pfcpi_pkg::REG_OUTER_DIVIDE:   outer_divide   = value;
      pfcpi_pkg::REG_DUTY_SPAN:      duty_span      = value;
      default:                       current_scale  = value;
    endcase
  endfunction

  function longint clamp_s32(longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  // Incremental PI step; the arithmetic shift rounds the increment towards minus infinity.
  function longint pi_update(longint drive, longint g_new, longint g_old, longint err,
                             longint err_prev, longint top);
    longint acc;
    longint nxt;
    acc = g_new * err - g_old * err_prev;
    nxt = drive + (acc >>> 24);
    if (nxt >= top) return top;
    if (nxt <= 0) return 0;
    return nxt;
  endfunction

  // Runs one tick of the current loop, and of the voltage loop once the divider has counted out.
  function void note_sample(logic [9:0] v_code, logic [9:0] i_code, logic [9:0] l_code);
    longint v_out;
    longint i_act;
    longint v_line;
    longint i_ref;
    longint err;
    tick_result_t res;
    v_out  = longint'(v_code) * VOLT_SCALE;
    i_act  = CUR_ZERO - longint'(i_code) * CUR_SCALE;
    v_line = longint'(l_code) * VOLT_SCALE;
    i_ref  = (amp_factor * v_line) >>> 24;
    if (i_ref > CUR_REF_LIMIT) i_ref = CUR_REF_LIMIT;

    // Inner current loop sets this tick's duty.
    err = clamp_s32(i_ref - i_act);
    cur_drive = pi_update(cur_drive, cur_gain_new, cur_gain_old, err, cur_err_prev,
                          CUR_DRIVE_TOP);
    cur_err_prev = err;
    res.duty_count    = 16'((duty_span * cur_drive) >>> 16);
    res.current_ref   = 22'(i_ref);
    res.outer_updated = 1'b0;

    // Outer voltage loop runs once the divider has counted out.
    if (tick_count + 1 >= outer_divide) begin
      tick_count = 0;
      err = clamp_s32(voltage_target - v_out);
      volt_drive = pi_update(volt_drive, volt_gain_new, volt_gain_old, err, volt_err_prev,
                             VOLT_DRIVE_TOP);
      volt_err_prev = err;
      amp_factor = ((current_scale * volt_drive) >>> 16) & 64'hFF_FFFF;
      res.outer_updated = 1'b1;
    end else begin
      tick_count = (tick_count + 1) & 255;
    end
    expected_ticks.push_back(res);
  endfunction

  function void compare_field(string name, longint want, longint got);
    if (want != got) begin
      failures++;
      if (failures <= 50)
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_result(tick_result_t got);
    tick_result_t want;
    if (expected_ticks.size() == 0) begin
      failures++;
      if (failures <= 50)
        $display("%0t: result with no tick pending, expected none, actual %0d/%0d/%0d",
                 $time, got.duty_count, got.current_ref, got.outer_updated);
      return;
    end
    want = expected_ticks.pop_front();
    compare_field("duty_count", want.duty_count, got.duty_count);
    compare_field("current_ref", want.current_ref, got.current_ref);
    compare_field("outer_updated", want.outer_updated, got.outer_updated);
  endfunction
endclass

module tb_top;

  localparam int unsigned SAMPLE_BITS     = 10;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned RANDOM_PHASES   = 9;
  localparam int unsigned ITEMS_PER_PHASE = 150;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [pfcpi_pkg::ADDR_W-1:0]      paddr;
  logic [pfcpi_pkg::DATA_W-1:0]      pwdata;
  logic [pfcpi_pkg::DATA_W-1:0]      prdata;
  logic                              pready;

  pfc_tick_board board;
  bit            no_idle = 1'b0;
  int unsigned   quiet_cycles = 0;

  pfcpi_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  pfcpi_out_if                             out_if ();

  pfc_cascaded_pi_controller_top #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Transfer monitor on both channels, with a watchdog on lack of progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        board.note_sample(in_if.out_volt_code, in_if.inductor_cur_code, in_if.line_volt_code);
      if (out_if.valid && out_if.ready)
        board.check_result({out_if.duty_count, out_if.current_ref, out_if.outer_updated});
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: random stalls, each begun once a result is already waiting; none when no_idle is set.
  initial begin : result_sink
    int unsigned stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(8, 0);
      if (stall != 0) begin
        out_if.ready = 1'b0;
        do @(posedge clk_i); while (!out_if.valid);
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      @(negedge clk_i);
    end
  end

  // Register write followed by a read back of the same address.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    board.load_reg(idx, value & reg_mask(idx));
    board.compare_field("register readback", value & reg_mask(idx), readback);
  endtask

  // One sample transfer after a random gap; valid stays high between back-to-back ticks.
  task automatic send_tick(input logic [9:0] v_code, input logic [9:0] i_code,
                           input logic [9:0] l_code);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(8, 0);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid             = 1'b1;
    in_if.out_volt_code     = v_code;
    in_if.inductor_cur_code = i_code;
    in_if.line_volt_code    = l_code;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // Holds the samples back until every pending tick has delivered its result.
  task automatic settle();
    in_if.valid = 1'b0;
    while (board.expected_ticks.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_reg(input logic [31:0] base, input reg_set_e mode);
    if (mode == SET_TOP) return 32'hFFFF_FFFF;
    if (mode == SET_FLOOR) return 32'h0;
    case ($urandom_range(9, 0))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      3, 4:    return base;
      default: return base * $urandom_range(40, 1) / 10;
    endcase
  endfunction

  task automatic program_regs(input reg_set_e mode);
    cfg_write(pfcpi_pkg::REG_VOLTAGE_TARGET, pick_reg(pfcpi_pkg::RST_VOLTAGE_TARGET, mode));
    cfg_write(pfcpi_pkg::REG_VOLT_GAIN_NEW, pick_reg(pfcpi_pkg::RST_VOLT_GAIN_NEW, mode));
    cfg_write(pfcpi_pkg::REG_VOLT_GAIN_OLD, pick_reg(pfcpi_pkg::RST_VOLT_GAIN_OLD, mode));
    cfg_write(pfcpi_pkg::REG_CUR_GAIN_NEW, pick_reg(pfcpi_pkg::RST_CUR_GAIN_NEW, mode));
    cfg_write(pfcpi_pkg::REG_CUR_GAIN_OLD, pick_reg(pfcpi_pkg::RST_CUR_GAIN_OLD, mode));
    cfg_write(pfcpi_pkg::REG_OUTER_DIVIDE, pick_reg(pfcpi_pkg::RST_OUTER_DIVIDE, mode));
    cfg_write(pfcpi_pkg::REG_DUTY_SPAN, pick_reg(pfcpi_pkg::RST_DUTY_SPAN, mode));
    cfg_write(pfcpi_pkg::REG_CURRENT_SCALE, pick_reg(pfcpi_pkg::RST_CURRENT_SCALE, mode));
  endtask

  // Mostly noise around a slowly moving operating point, some uniform codes, some rails.
  function automatic logic [9:0] gen_code(input int centre);
    int unsigned pick;
    int x;
    pick = $urandom_range(99, 0);
    if (pick < 60) begin
      x = centre + int'($urandom_range(32, 0)) - 16;
      if (x < 0) x = 0;
      if (x > 1023) x = 1023;
      return 10'(x);
    end
    if (pick < 85) return 10'($urandom_range(1023, 0));
    return pick[0] ? 10'h3FF : 10'h000;
  endfunction

  task automatic run_directed();
    // Rail and alternating-bit samples with the reset settings.
    send_tick(10'h000, 10'h000, 10'h000);
    send_tick(10'h3FF, 10'h3FF, 10'h3FF);
    send_tick(10'h3FF, 10'h000, 10'h3FF);
    send_tick(10'h000, 10'h3FF, 10'h000);
    send_tick(10'h2AA, 10'h155, 10'h2AA);
    send_tick(10'h155, 10'h2AA, 10'h155);

    // A divider of zero runs the voltage loop every tick; full setpoint and gain push the
    // amplitude factor to its top, so the current reference saturates.
    settle();
    cfg_write(pfcpi_pkg::REG_OUTER_DIVIDE, 32'h0);
    cfg_write(pfcpi_pkg::REG_VOLTAGE_TARGET, 32'hFFFF_FFFF);
    cfg_write(pfcpi_pkg::REG_VOLT_GAIN_NEW, 32'hFFFF_FFFF);
    cfg_write(pfcpi_pkg::REG_VOLT_GAIN_OLD, 32'h0);
    cfg_write(pfcpi_pkg::REG_CURRENT_SCALE, 32'hFFFF_FFFF);
    repeat (3) send_tick(10'h000, 10'h000, 10'h3FF);
    send_tick(10'h000, 10'h000, 10'h000);

    // A zero setpoint gives a large negative voltage error and drives the voltage loop to the floor.
    settle();
    cfg_write(pfcpi_pkg::REG_VOLTAGE_TARGET, 32'h0);
    repeat (3) send_tick(10'h3FF, 10'h3FF, 10'h3FF);

    // Divider lowered below the running count: the next tick must update the outer loop.
    settle();
    cfg_write(pfcpi_pkg::REG_OUTER_DIVIDE, 32'd20);
    repeat (8) send_tick(10'($urandom_range(1023, 0)), 10'($urandom_range(1023, 0)),
                         10'($urandom_range(1023, 0)));
    settle();
    cfg_write(pfcpi_pkg::REG_OUTER_DIVIDE, 32'd3);
    repeat (2) send_tick(10'($urandom_range(1023, 0)), 10'($urandom_range(1023, 0)),
                         10'($urandom_range(1023, 0)));
  endtask

  task automatic run_random_phase(input int unsigned phase);
    int centre_v;
    int centre_i;
    int centre_l;
    int unsigned n;
    settle();
    no_idle = ($urandom_range(3, 0) == 0);
    program_regs(phase == 0 ? SET_TOP : (phase == 1 ? SET_FLOOR : SET_MIXED));
    centre_v = $urandom_range(1023, 0);
    centre_i = $urandom_range(1023, 0);
    centre_l = $urandom_range(1023, 0);
    for (n = 0; n < ITEMS_PER_PHASE; n++) begin
      // Operating point shifts now and then.
      if ($urandom_range(31, 0) == 0) begin
        centre_v = $urandom_range(1023, 0);
        centre_i = $urandom_range(1023, 0);
        centre_l = $urandom_range(1023, 0);
      end
      // Halfway through, let the block drain completely.
      if (n == ITEMS_PER_PHASE / 2) settle();
      send_tick(gen_code(centre_v), gen_code(centre_i), gen_code(centre_l));
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    board                   = new();
    rst_ni                  = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    in_if.valid             = 1'b0;
    in_if.out_volt_code     = '0;
    in_if.inductor_cur_code = '0;
    in_if.line_volt_code    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    for (phase = 0; phase < RANDOM_PHASES; phase++) run_random_phase(phase);

    // Drain and allow for the longest tick before the verdict.
    settle();
    repeat (30) @(negedge clk_i);
    if (board.expected_ticks.size() != 0)
      $display("%0t: %0d ticks still awaiting a result", $time, board.expected_ticks.size());
    if (board.failures == 0 && board.expected_ticks.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/pfcpi_pkg.sv
rtl/pfcpi_if.sv
rtl/pfcpi_regs.sv
rtl/pfcpi_sequencer.sv
rtl/pfcpi_datapath.sv
rtl/pfc_cascaded_pi_controller_top.sv
tb/tb_top.sv
